// ===== design/rank_indexer_top_defines.svh =====
// Assertion macros for the rank indexer block.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef RANK_INDEXER_TOP_DEFINES_SVH
`define RANK_INDEXER_TOP_DEFINES_SVH

`ifndef SYNTH
`define RKI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rank_indexer check failed");
`define RKI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rank_indexer check failed");
`else
`define RKI_ASSERT_NOW(lbl, ante, cons)
`define RKI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/rki_pkg.sv =====
// Shared constants and types of the rank indexer.
// No dependencies; imported by the channel interfaces and the top level.
package rki_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 32;
  localparam int RANK_W    = 6;
  localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_KEY   = 4'b0010,
    S_KEYLD = 4'b0100,
    S_SCAN  = 4'b1000
  } rki_state_t;

  typedef logic [CNT_W-1:0]  rki_cnt_t;
  typedef logic [ADDR_W-1:0] rki_addr_t;

endpackage

// ===== design/rki_if.sv =====
// Valid/ready channel interfaces of the rank indexer: input values and ranks.
// Depends on rki_pkg for field widths.
interface rki_in_if import rki_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_value;

  modport source (output valid, output value, output last_value, input ready);
  modport sink   (input valid, input value, input last_value, output ready);
endinterface

interface rki_out_if import rki_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;
  logic              last_rank;
  logic              overflow;

  modport source (output valid, output rank, output last_rank, output overflow, input ready);
  modport sink   (input valid, input rank, input last_rank, input overflow, output ready);
endinterface

// ===== design/rank_indexer_top.sv =====
// Top level of the rank indexer: value store, compare sequencer, result register.
// Depends on rki_pkg, rki_if.sv and rank_indexer_top_defines.svh.
//
// Usage:
// in_chan carries signed 32-bit values with a last_value mark. Values load
// one per cycle into a store of MAX_ITEMS entries; values beyond that are
// dropped and set a sticky overflow mark. A transfer with last_value set
// ends the run and starts ranking; in_chan.ready stays low until ranking ends.
// out_chan then gives one rank per stored value, in arrival order; the final
// one carries last_rank and the overflow mark. For a run of n values, each rank
// is computed by a key read and a scan through the single read port of the value
// store and the one shared signed comparator, which compares all n entries; the
// next rank starts only when the scan of the current one is done.
// The result register holds a rank until out_chan takes it; while it waits,
// the scan of the next rank finishes and then holds. After the final rank is
// computed, in_chan is ready again even if that rank still waits.
// Reset clears count, overflow mark, sequencer and result valid; the store
// needs no clearing since only entries written in the current run are read.
`include "rank_indexer_top_defines.svh"

module rank_indexer_top import rki_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  rki_in_if.sink        in_chan,
  rki_out_if.source     out_chan
);

  logic signed [VALUE_W-1:0] mem [MAX_ITEMS];

  rki_state_t                state_r, state_nxt;
  rki_cnt_t                  count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  rki_addr_t                 k_r, k_nxt;
  rki_cnt_t                  j_r, j_nxt;
  logic [RANK_W-1:0]         acc_r, acc_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic signed [VALUE_W-1:0] rd_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]         out_rank_r, out_rank_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic       in_xfer;
  logic       wr_en;
  logic       rd_en;
  rki_addr_t  rd_addr;
  logic       lt;
  logic       slot_free;
  logic       scan_done;
  logic       last_k;
  logic [RANK_W-1:0] rank_sum;

  assign in_chan.ready = (state_r == S_LOAD);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign wr_en         = in_xfer && (count_r < CNT_W'(MAX_ITEMS));

  assign lt        = rd_data_r < key_r;
  assign rank_sum  = acc_r + RANK_W'(lt);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign scan_done = (j_r == count_r);
  assign last_k    = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    acc_nxt       = acc_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    out_rank_nxt  = out_rank_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    rd_en         = 1'b0;
    rd_addr       = j_r[ADDR_W-1:0];

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (wr_en) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.last_value) begin
            k_nxt     = '0;
            state_nxt = S_KEY;
          end
        end
      end
      S_KEY: begin
        rd_en     = 1'b1;
        rd_addr   = k_r;
        state_nxt = S_KEYLD;
      end
      S_KEYLD: begin
        key_nxt   = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = '0;
        j_nxt     = CNT_W'(1);
        acc_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!scan_done) begin
          acc_nxt = rank_sum;
          rd_en   = 1'b1;
          j_nxt   = j_r + CNT_W'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rank_nxt  = rank_sum;
          out_last_nxt  = last_k;
          out_ovf_nxt   = last_k && ovf_r;
          if (last_k) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + ADDR_W'(1);
            state_nxt = S_KEY;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= in_chan.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    key_r      <= key_nxt;
    out_rank_r <= out_rank_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.rank      = out_rank_r;
  assign out_chan.last_rank = out_last_r;
  assign out_chan.overflow  = out_ovf_r;

  `RKI_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ITEMS))
  `RKI_ASSERT_NOW(a_scan_index, state_r == S_SCAN, (j_r != '0) && (j_r <= count_r))
  `RKI_ASSERT_NOW(a_ovf_on_last, out_valid_r && out_ovf_r, out_last_r)
  `RKI_ASSERT_NEXT(a_full_drop, in_xfer && (count_r == CNT_W'(MAX_ITEMS)), ovf_r)

endmodule
